/* rtl/core/cfbc_pkg.sv */
// Shared types, constants and helpers for the color blob centroid block.
package cfbc_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned QDepth    = 4;

  localparam int unsigned CoordW = 11;
  localparam int unsigned SumW   = 33;
  localparam int unsigned CntW   = 23;
  localparam int unsigned BndW   = 24;
  localparam int unsigned DivSteps = CoordW;
  localparam int unsigned DivStepW = $clog2(DivSteps);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [BndW-1:0] YellowRst = 24'hC8C864;
  localparam logic [BndW-1:0] BlueRst   = 24'h3C648C;
  localparam logic [BndW-1:0] GreenRst  = 24'hA09682;

  localparam logic [1:0] RegYellow = 2'd0;
  localparam logic [1:0] RegBlue   = 2'd1;
  localparam logic [1:0] RegGreen  = 2'd2;

  localparam logic [1:0] ColYellow = 2'd0;
  localparam logic [1:0] ColBlue   = 2'd1;
  localparam logic [1:0] ColGreen  = 2'd2;
  localparam logic [1:0] ColNone   = 2'd3;

  typedef struct packed {
    logic [1:0]        color;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
  } q_entry_t;

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] s, logic [CoordW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW+1)'(v);
    return t[SumW] ? {SumW{1'b1}} : t[SumW-1:0];
  endfunction

endpackage

/* rtl/core/cfbc_front.sv */
// Front end: threshold registers, pixel request intake and color classification.
module cfbc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [cfbc_pkg::BndW-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pix_blue,
  input  logic [7:0]                  in_pix_green,
  input  logic [7:0]                  in_pix_red,
  input  logic [cfbc_pkg::CoordW-1:0] in_col,
  input  logic [cfbc_pkg::CoordW-1:0] in_row,
  input  logic                        in_last_pixel,
  input  logic                        q_full,
  output logic                        q_push,
  output cfbc_pkg::q_entry_t          q_wdata
);

  logic [cfbc_pkg::BndW-1:0] ylw_r, blu_r, grn_r;
  logic hit_y, hit_b, hit_g, in_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ylw_r <= cfbc_pkg::YellowRst;
      blu_r <= cfbc_pkg::BlueRst;
      grn_r <= cfbc_pkg::GreenRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cfbc_pkg::RegYellow: ylw_r <= cfg_wdata;
        cfbc_pkg::RegBlue:   blu_r <= cfg_wdata;
        cfbc_pkg::RegGreen:  grn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign hit_y = (in_pix_red >= ylw_r[23:16]) && (in_pix_green > ylw_r[15:8]) &&
                 (in_pix_blue < ylw_r[7:0]);
  assign hit_b = (in_pix_red < blu_r[23:16]) && (in_pix_green < blu_r[15:8]) &&
                 (in_pix_blue >= blu_r[7:0]);
  assign hit_g = (in_pix_red < grn_r[23:16]) && (in_pix_green >= grn_r[15:8]) &&
                 (in_pix_blue < grn_r[7:0]);
  assign in_frame = (32'(in_col) < cfbc_pkg::MaxWidth) && (32'(in_row) < cfbc_pkg::MaxHeight);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.col  = in_col;
    q_wdata.row  = in_row;
    q_wdata.last = in_last_pixel;
    if (!in_frame)  q_wdata.color = cfbc_pkg::ColNone;
    else if (hit_y) q_wdata.color = cfbc_pkg::ColYellow;
    else if (hit_b) q_wdata.color = cfbc_pkg::ColBlue;
    else if (hit_g) q_wdata.color = cfbc_pkg::ColGreen;
    else            q_wdata.color = cfbc_pkg::ColNone;
  end

endmodule

/* rtl/core/cfbc_fifo.sv */
// Short queue of classified pixels between front end and accumulator.
module cfbc_fifo #(
  parameter int unsigned DEPTH = cfbc_pkg::QDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cfbc_pkg::q_entry_t           wdata,
  input  logic                         pop,
  output cfbc_pkg::q_entry_t           rdata,
  output logic                         not_empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);

  cfbc_pkg::q_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

  assign rdata     = mem[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign full      = (level_r == LW'(DEPTH));
  assign level     = level_r;

endmodule

/* rtl/core/cfbc_div.sv */
// Bit-serial divider: two sums over one count, one quotient bit per cycle.
module cfbc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cfbc_pkg::SumW-1:0]   num_a,
  input  logic [cfbc_pkg::SumW-1:0]   num_b,
  input  logic [cfbc_pkg::CntW-1:0]   den,
  output logic                        busy,
  output logic                        done,
  output logic [cfbc_pkg::CoordW-1:0] quo_a,
  output logic [cfbc_pkg::CoordW-1:0] quo_b
);

  localparam int unsigned RW = cfbc_pkg::SumW + 1;
  localparam int unsigned QW = cfbc_pkg::CoordW;

  logic          busy_r, done_r;
  logic [cfbc_pkg::DivStepW-1:0] step_r;
  logic [RW-1:0] rem_a_r, rem_b_r, dsh_r;
  logic [QW-1:0] qa_r, qb_r;
  logic          ge_a, ge_b;

  assign ge_a = (rem_a_r >= dsh_r);
  assign ge_b = (rem_b_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= cfbc_pkg::DivStepW'(cfbc_pkg::DivSteps - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_a_r <= RW'(num_a);
      rem_b_r <= RW'(num_b);
      dsh_r   <= RW'(den) << (QW - 1);
      qa_r    <= '0;
      qb_r    <= '0;
    end else if (busy_r) begin
      if (ge_a) rem_a_r <= rem_a_r - dsh_r;
      if (ge_b) rem_b_r <= rem_b_r - dsh_r;
      qa_r  <= {qa_r[QW-2:0], ge_a};
      qb_r  <= {qb_r[QW-2:0], ge_b};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign quo_a = qa_r;
  assign quo_b = qb_r;

endmodule

/* rtl/core/cfbc_back.sv */
// Back end: per-color sums and counts, end-of-frame selection and result register.
module cfbc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  cfbc_pkg::q_entry_t          q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [1:0]                  out_color,
  output logic [cfbc_pkg::CoordW-1:0] out_center_x,
  output logic [cfbc_pkg::CoordW-1:0] out_center_y
);

  localparam int unsigned SW = cfbc_pkg::SumW;
  localparam int unsigned CW = cfbc_pkg::CntW;

  logic [SW-1:0] sum_col_r [3];
  logic [SW-1:0] sum_row_r [3];
  logic [CW-1:0] cnt_r     [3];
  logic [SW-1:0] sum_col_nxt [3];
  logic [SW-1:0] sum_row_nxt [3];
  logic [CW-1:0] cnt_nxt     [3];

  logic          fin_r;
  logic          out_valid_r, out_found_r;
  logic [1:0]    out_color_r, sel_color_r;
  logic [cfbc_pkg::CoordW-1:0] out_cx_r, out_cy_r;

  logic          found_c;
  logic [1:0]    sel_c;
  logic [SW-1:0] div_na, div_nb;
  logic [CW-1:0] div_den;
  logic          div_start, div_busy, div_done;
  logic [cfbc_pkg::CoordW-1:0] quo_a, quo_b;

  // a frame end waits until no request is in flight or held in the output register
  assign q_pop = q_not_empty && !fin_r &&
                 !(q_rdata.last && (div_busy || div_done || out_valid_r));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_col_nxt[k] = sum_col_r[k];
      sum_row_nxt[k] = sum_row_r[k];
      cnt_nxt[k]     = cnt_r[k];
      if (fin_r) begin
        sum_col_nxt[k] = '0;
        sum_row_nxt[k] = '0;
        cnt_nxt[k]     = '0;
      end else if (q_pop && q_rdata.color == 2'(k) && cnt_r[k] != cfbc_pkg::CntMax) begin
        sum_col_nxt[k] = cfbc_pkg::sat_add(sum_col_r[k], q_rdata.col);
        sum_row_nxt[k] = cfbc_pkg::sat_add(sum_row_r[k], q_rdata.row);
        cnt_nxt[k]     = cnt_r[k] + 1'b1;
      end
    end
  end

  always_comb begin
    found_c = 1'b1;
    if (cnt_r[0] != '0)      sel_c = cfbc_pkg::ColYellow;
    else if (cnt_r[1] != '0) sel_c = cfbc_pkg::ColBlue;
    else if (cnt_r[2] != '0) sel_c = cfbc_pkg::ColGreen;
    else begin
      sel_c   = cfbc_pkg::ColNone;
      found_c = 1'b0;
    end
    case (sel_c)
      cfbc_pkg::ColYellow: begin
        div_na = sum_col_r[0]; div_nb = sum_row_r[0]; div_den = cnt_r[0];
      end
      cfbc_pkg::ColBlue: begin
        div_na = sum_col_r[1]; div_nb = sum_row_r[1]; div_den = cnt_r[1];
      end
      cfbc_pkg::ColGreen: begin
        div_na = sum_col_r[2]; div_nb = sum_row_r[2]; div_den = cnt_r[2];
      end
      default: begin
        div_na = '0; div_nb = '0; div_den = '0;
      end
    endcase
  end

  assign div_start = fin_r && found_c;

  cfbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_a (div_na),
    .num_b (div_nb),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        sum_col_r[k] <= '0;
        sum_row_r[k] <= '0;
        cnt_r[k]     <= '0;
      end
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        sum_col_r[k] <= sum_col_nxt[k];
        sum_row_r[k] <= sum_row_nxt[k];
        cnt_r[k]     <= cnt_nxt[k];
      end
      fin_r <= q_pop && q_rdata.last;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if ((fin_r && !found_c) || div_done) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) sel_color_r <= sel_c;
    if (fin_r && !found_c) begin
      out_found_r <= 1'b0;
      out_color_r <= '0;
      out_cx_r    <= '0;
      out_cy_r    <= '0;
    end else if (div_done) begin
      out_found_r <= 1'b1;
      out_color_r <= sel_color_r;
      out_cx_r    <= quo_a;
      out_cy_r    <= quo_b;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_color    = out_color_r;
  assign out_center_x = out_cx_r;
  assign out_center_y = out_cy_r;

endmodule

/* rtl/core/color_blob_centroid.sv */
// Top level: pixel stream in, one centroid request per frame out.
// Throughput: one pixel per cycle while the queue is not full; pixels queue behind a held last pixel.
// Path of a last pixel to its request: queue, accumulate, selection cycle, bit-serial divide,
//   output register; if nothing matched, the divide is skipped.
// A later last pixel waits in the queue until the divider is idle and the request has left.
// Reset (rst_n low, synchronous): thresholds to defaults, sums, counts and queue cleared.
module color_blob_centroid #(
  parameter int unsigned Q_DEPTH = cfbc_pkg::QDepth
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [cfbc_pkg::BndW-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_pix_blue,
  input  logic [7:0]                  in_pix_green,
  input  logic [7:0]                  in_pix_red,
  input  logic [cfbc_pkg::CoordW-1:0] in_col,
  input  logic [cfbc_pkg::CoordW-1:0] in_row,
  input  logic                        in_last_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [1:0]                  out_color,
  output logic [cfbc_pkg::CoordW-1:0] out_center_x,
  output logic [cfbc_pkg::CoordW-1:0] out_center_y
);

  cfbc_pkg::q_entry_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_not_empty;
  logic [$clog2(Q_DEPTH+1)-1:0] q_level;

  cfbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pix_blue   (in_pix_blue),
    .in_pix_green  (in_pix_green),
    .in_pix_red    (in_pix_red),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_last_pixel (in_last_pixel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  cfbc_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full),
    .level     (q_level)
  );

  cfbc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_color    (out_color),
    .out_center_x (out_center_x),
    .out_center_y (out_center_y)
  );

`ifndef NO_ASSERTIONS
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_color == '0 && out_center_x == '0 && out_center_y == '0))
    else $error("empty frame request carries nonzero fields");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_level) <= Q_DEPTH)
    else $error("queue level beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_level == '0) |=> (q_level != '0))
    else $error("accepted pixel lost before queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty queue");
`endif

endmodule
